@@ rtl/erle_pkg.sv @@
// Package with item types, character codes and hex helpers of the escaped RLE byte decoder.
package erle_pkg;

  typedef struct packed {
    logic [7:0] enc_char;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [11:0] repeat_count;
    logic        truncated_error;
    logic        final_result;
  } out_item_t;

  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChStar      = 8'h2a;
  localparam logic [7:0] ChX         = 8'h78;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6e;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChUpperF    = 8'h46;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] ChLowerF    = 8'h66;

  localparam logic [7:0] RunShortLimit = 8'd5;

  // Digit value as a hex conversion without checking gives it.
  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= ChUpperA && c <= ChUpperF) begin
      v = c - ChUpperA + 8'd10;
    end else if (c >= ChLowerA && c <= ChLowerF) begin
      v = c - ChLowerA + 8'd10;
    end else begin
      v = c - ChZero;
    end
    return v;
  endfunction

  function automatic logic [7:0] hex_byte(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] h;
    h = hex_val(hi);
    return {h[3:0], 4'b0000} + hex_val(lo);
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      ChZero:  v = 8'h00;
      ChB:     v = 8'h08;
      ChF:     v = 8'h0c;
      ChN:     v = 8'h0a;
      ChR:     v = 8'h0d;
      ChT:     v = 8'h09;
      default: v = c;
    endcase
    return v;
  endfunction

  function automatic out_item_t make_item(input logic [7:0] b, input logic [11:0] cnt,
                                          input logic err);
    out_item_t o;
    o.data_byte       = b;
    o.repeat_count    = cnt;
    o.truncated_error = err;
    o.final_result    = 1'b0;
    return o;
  endfunction

endpackage

@@ rtl/escaped_rle_byte_decoder.sv @@
// Top level of the escaped RLE byte decoder: decode state machine and result queue.
//
// The decoder takes one encoded character per item on the input channel and
// emits (byte, repeat count) result items on the output channel. A backslash
// starts an escape (hex byte after x, control bytes for 0 b f n r t, the
// character itself otherwise); once a byte has been produced, a star plus two
// hex digits repeats the previous byte as one result item. The end of a message
// is marked on its last character; the last result of the message carries
// final_result, a message that ends inside an escape gives one error item, and
// all decode state returns to its reset value afterwards. Each character is
// decoded in the cycle it is accepted and its results (at most two) are written
// into a four-entry result queue, so the block takes one item per cycle as long
// as the output side keeps taking one result per cycle. The input ready depends
// only on queue room: it is high whenever at least two queue entries are free.
// The one case that yields two results (a message ending on the first digit of
// a star sequence) fills the queue faster than it drains, which can stall the
// input. Each result is registered in the queue and leaves it in order of writing.
module escaped_rle_byte_decoder
  import erle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhEsc   = 3'd1,
    PhEscX  = 3'd2,
    PhEscX1 = 3'd3,
    PhStar  = 3'd4,
    PhStar1 = 3'd5
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [7:0] prev_q, prev_d;
  logic       have_prev_q, have_prev_d;

  out_item_t  res0, res1;
  logic       res0_v, res1_v;

  logic       in_fire, out_fire;
  logic [7:0] c;
  logic       last;
  logic [7:0] run_code;
  logic [11:0] run_len;

  // Result queue.
  out_item_t  q_mem [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic [1:0] wr_num;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;
  assign c        = in_item_i.enc_char;
  assign last     = in_item_i.end_of_message;

  // Run length from the two star digits: long runs for small codes.
  assign run_code = hex_byte(held_q, c);
  always_comb begin
    if (run_code >= RunShortLimit) begin
      run_len = {4'b0000, run_code - 8'd1};
    end else begin
      case (run_code[2:0])
        3'd0:    run_len = 12'h0ff;
        3'd1:    run_len = 12'h1ff;
        3'd2:    run_len = 12'h3ff;
        3'd3:    run_len = 12'h7ff;
        default: run_len = 12'hfff;
      endcase
    end
  end

  // Decode of one character against the current phase.
  always_comb begin
    phase_d     = phase_q;
    held_d      = held_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    res0        = make_item(8'h00, 12'd0, 1'b0);
    res1        = make_item(8'h00, 12'd0, 1'b0);
    res0_v      = 1'b0;
    res1_v      = 1'b0;

    unique case (phase_q)
      PhEsc: begin
        if (c == ChX) begin
          if (last) begin
            res0   = make_item(8'h00, 12'd0, 1'b1);
            res0_v = 1'b1;
          end else begin
            phase_d = PhEscX;
          end
        end else begin
          res0        = make_item(esc_map(c), 12'd1, 1'b0);
          res0_v      = 1'b1;
          prev_d      = esc_map(c);
          have_prev_d = 1'b1;
          phase_d     = PhIdle;
        end
      end
      PhEscX: begin
        if (last) begin
          res0   = make_item(8'h00, 12'd0, 1'b1);
          res0_v = 1'b1;
        end else begin
          held_d  = c;
          phase_d = PhEscX1;
        end
      end
      PhEscX1: begin
        res0        = make_item(hex_byte(held_q, c), 12'd1, 1'b0);
        res0_v      = 1'b1;
        prev_d      = hex_byte(held_q, c);
        have_prev_d = 1'b1;
        phase_d     = PhIdle;
      end
      PhStar: begin
        if (last) begin
          // The pending star leaves as a literal, then this character alone (an error item for a backslash).
          res0   = make_item(ChStar, 12'd1, 1'b0);
          res0_v = 1'b1;
          res1_v = 1'b1;
          if (c == ChBackslash) begin
            res1 = make_item(8'h00, 12'd0, 1'b1);
          end else begin
            res1 = make_item(c, 12'd1, 1'b0);
          end
        end else begin
          held_d  = c;
          phase_d = PhStar1;
        end
      end
      PhStar1: begin
        res0    = make_item(prev_q, run_len, 1'b0);
        res0_v  = 1'b1;
        phase_d = PhIdle;
      end
      default: begin
        // Idle; unused phase codes behave the same way.
        if (c == ChBackslash) begin
          if (last) begin
            res0   = make_item(8'h00, 12'd0, 1'b1);
            res0_v = 1'b1;
          end else begin
            phase_d = PhEsc;
          end
        end else if (c == ChStar && have_prev_q && !last) begin
          phase_d = PhStar;
        end else begin
          res0        = make_item(c, 12'd1, 1'b0);
          res0_v      = 1'b1;
          prev_d      = c;
          have_prev_d = 1'b1;
        end
      end
    endcase

    // The last character of a message marks its last result and clears state.
    if (last) begin
      if (res1_v) begin
        res1.final_result = 1'b1;
      end else begin
        res0.final_result = 1'b1;
      end
      phase_d     = PhIdle;
      held_d      = 8'h00;
      prev_d      = 8'h00;
      have_prev_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      held_q      <= 8'h00;
      prev_q      <= 8'h00;
      have_prev_q <= 1'b0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      held_q      <= held_d;
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
    end
  end

  // Queue bookkeeping: up to two writes and one read per cycle.
  assign wr_num      = in_fire ? ({1'b0, res0_v} + {1'b0, res1_v}) : 2'd0;
  assign in_ready_o  = (count_q <= 3'd2);
  assign out_valid_o = (count_q != 3'd0);
  assign out_item_o  = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + wr_num;
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + {1'b0, wr_num} - {2'b00, out_fire};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res0_v) begin
      q_mem[wr_ptr_q] <= res0;
    end
    if (in_fire && res1_v) begin
      q_mem[wr_ptr_q + 2'd1] <= res1;
    end
  end

endmodule
